// ===== sv/gershgorin_eigen_bounds_defines.svh =====
// Assertion macros for the Gershgorin bounds RTL.
`ifndef GERSHGORIN_EIGEN_BOUNDS_DEFINES_SVH
`define GERSHGORIN_EIGEN_BOUNDS_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define GEB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define GEB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/gebnd_pkg.sv =====
// Package with shared types and constants of the Gershgorin bounds block.
`timescale 1ns / 1ps

package gebnd_pkg;

  localparam int INDEX_BITS_DEFAULT = 32;
  localparam int MID_DEPTH_DEFAULT  = 4;
  localparam int OUT_DEPTH_DEFAULT  = 2;

  localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;

  // Input request as it arrives at the block
  typedef struct packed {
    logic               entry_present;
    logic [31:0]        col_index;
    logic signed [31:0] entry_value;
    logic               row_end;
    logic               matrix_end;
  } in_item_t;

  // Result request
  typedef struct packed {
    logic signed [47:0] lower_bound;
    logic signed [47:0] upper_bound;
  } out_item_t;

  // Classified request passed from front to back
  typedef struct packed {
    logic               is_off;
    logic               is_diag;
    logic signed [31:0] value;
    logic [31:0]        mag;
    logic               close;
    logic               mend;
  } cls_item_t;

endpackage

// ===== sv/gebnd_fifo.sv =====
// Small first-word-fall-through queue of flip-flops.
`timescale 1ns / 1ps

module gebnd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW:0]      wr_ptr;
  logic [AW:0]      rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (wr_ptr[AW] != rd_ptr[AW]) && (wr_ptr[AW-1:0] == rd_ptr[AW-1:0]);
  assign empty   = (wr_ptr == rd_ptr);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr[AW-1:0]];

  // Store pushed request
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr[AW-1:0]] <= wdata;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

endmodule

// ===== sv/gebnd_front.sv =====
// Front end: accepts requests, tests for the diagonal and takes magnitudes.
`timescale 1ns / 1ps

module gebnd_front #(
  parameter int INDEX_BITS = gebnd_pkg::INDEX_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  row_offset_we,
  input  logic [31:0]           row_offset_wdata,
  input  gebnd_pkg::in_item_t   entry,
  input  logic                  push,
  output logic                  full,
  output logic                  q_push,
  output gebnd_pkg::cls_item_t  q_item,
  input  logic                  q_full
);

  import gebnd_pkg::*;

  // Diagonal column sum carries one bit above the 32-bit operands
  localparam int CMP_BITS = (INDEX_BITS < 33) ? INDEX_BITS : 33;

  logic [31:0] row_offset;
  logic [31:0] row_counter;
  logic [32:0] diag_col;
  logic [32:0] col_ext;
  logic        accept;
  logic        close;
  logic        is_diag;

  assign accept   = push && !q_full;
  assign full     = q_full;
  assign close    = entry.row_end || entry.matrix_end;
  assign diag_col = {1'b0, row_counter} + {1'b0, row_offset};
  assign col_ext  = {1'b0, entry.col_index};
  assign is_diag  = (diag_col[CMP_BITS-1:0] == col_ext[CMP_BITS-1:0]);

  // Classify; drop markers that neither add nor close
  always_comb begin
    q_item.is_off  = entry.entry_present && !is_diag;
    q_item.is_diag = entry.entry_present && is_diag;
    q_item.value   = entry.entry_value;
    q_item.mag     = entry.entry_value[31] ? (~entry.entry_value + 32'd1)
                                           : entry.entry_value;
    q_item.close   = close;
    q_item.mend    = entry.matrix_end;
    q_push         = accept && (entry.entry_present || close);
  end

  // Hold offset; advance row counter on row close, clear at matrix end
  always_ff @(posedge clk) begin
    if (rst) begin
      row_offset  <= '0;
      row_counter <= '0;
    end else begin
      if (row_offset_we) begin
        row_offset <= row_offset_wdata;
      end
      if (accept && close) begin
        row_counter <= entry.matrix_end ? 32'd0 : row_counter + 32'd1;
      end
    end
  end

endmodule

// ===== sv/gebnd_back.sv =====
// Back end: accumulates rows, then folds row bounds into the running bounds.
`timescale 1ns / 1ps
`include "gershgorin_eigen_bounds_defines.svh"

module gebnd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  gebnd_pkg::cls_item_t  q_item,
  output logic                  q_pop,
  input  logic                  o_full,
  output logic                  o_push,
  output gebnd_pkg::out_item_t  o_item
);

  import gebnd_pkg::*;

  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    logic signed [47:0] r;
    if (v[48] != v[47]) begin
      r = v[48] ? MIN48 : MAX48;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  // Row accumulator (stage A)
  logic [46:0]        acc_sum;
  logic signed [31:0] acc_diag;
  logic [47:0]        sum_raw;
  logic [46:0]        sum_sat;
  logic [46:0]        sum_new;
  logic signed [31:0] diag_new;

  // Closed row (stage B)
  logic               b_valid;
  logic               b_mend;
  logic [46:0]        b_sum;
  logic signed [31:0] b_diag;
  logic signed [48:0] hi_raw;
  logic signed [48:0] lo_raw;
  logic signed [47:0] hi_sat;
  logic signed [47:0] lo_sat;

  logic signed [47:0] run_min;
  logic signed [47:0] run_max;
  logic signed [47:0] min_new;
  logic signed [47:0] max_new;

  logic advance;
  logic take;

  // Stall both stages while the result queue is full
  assign advance = !o_full;
  assign take    = advance && !q_empty;
  assign q_pop   = take;

  // Add magnitude with saturation; last diagonal wins
  assign sum_raw  = {1'b0, acc_sum} + {16'b0, q_item.mag};
  assign sum_sat  = sum_raw[47] ? {47{1'b1}} : sum_raw[46:0];
  assign sum_new  = q_item.is_off ? sum_sat : acc_sum;
  assign diag_new = q_item.is_diag ? q_item.value : acc_diag;

  // Row bounds, saturated to 48 bits, then compared with running bounds
  assign hi_raw  = {{17{b_diag[31]}}, b_diag} + $signed({2'b00, b_sum});
  assign lo_raw  = {{17{b_diag[31]}}, b_diag} - $signed({2'b00, b_sum});
  assign hi_sat  = sat48(hi_raw);
  assign lo_sat  = sat48(lo_raw);
  assign max_new = (hi_sat > run_max) ? hi_sat : run_max;
  assign min_new = (lo_sat < run_min) ? lo_sat : run_min;

  assign o_push             = advance && b_valid && b_mend;
  assign o_item.lower_bound = min_new;
  assign o_item.upper_bound = max_new;

  // Advance stage A and stage B together
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_sum  <= '0;
      acc_diag <= '0;
      b_valid  <= 1'b0;
      run_min  <= MAX48;
      run_max  <= MIN48;
    end else if (advance) begin
      b_valid <= take && q_item.close;
      b_mend  <= q_item.mend;
      b_sum   <= sum_new;
      b_diag  <= diag_new;
      if (take) begin
        if (q_item.close) begin
          acc_sum  <= '0;
          acc_diag <= '0;
        end else begin
          acc_sum  <= sum_new;
          acc_diag <= diag_new;
        end
      end
      if (b_valid) begin
        if (b_mend) begin
          run_min <= MAX48;
          run_max <= MIN48;
        end else begin
          run_min <= min_new;
          run_max <= max_new;
        end
      end
    end
  end

  `GEB_ASSERT_NEXT(a_close_hands_over, take && q_item.close, b_valid && acc_sum == '0 && acc_diag == '0, "row close did not reach stage B")
  `GEB_ASSERT_NEXT(a_bounds_cleared, advance && b_valid && b_mend, run_min == MAX48 && run_max == MIN48, "running bounds not cleared after result")
  `GEB_ASSERT_NEXT(a_bounds_track, advance && b_valid && !b_mend, run_min <= $past(lo_sat) && run_max >= $past(hi_sat), "running bounds miss a row")
  `GEB_ASSERT_SAME(a_result_from_close, o_push, b_valid && b_mend, "result without matrix close")

endmodule

// ===== sv/gershgorin_eigen_bounds.sv =====
// Top level of the Gershgorin eigenvalue bounds block over CSR rows.
// Throughput: one request per cycle, except while the mid or result queue is full.
// Path: a matrix-end request passes the front queue write, the row stage, then the
//   bound compare into the result queue (stalled while that queue is full).
// Reset: synchronous rst clears row offset, counters and running bounds.
`timescale 1ns / 1ps

module gershgorin_eigen_bounds #(
  parameter int INDEX_BITS = gebnd_pkg::INDEX_BITS_DEFAULT,
  parameter int MID_DEPTH  = gebnd_pkg::MID_DEPTH_DEFAULT,
  parameter int OUT_DEPTH  = gebnd_pkg::OUT_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 row_offset_we,
  input  logic [31:0]          row_offset_wdata,
  input  gebnd_pkg::in_item_t  entry,
  input  logic                 push,
  output logic                 full,
  output gebnd_pkg::out_item_t result,
  output logic                 empty,
  input  logic                 pop
);

  import gebnd_pkg::*;

  cls_item_t q_in;
  cls_item_t q_out;
  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;
  out_item_t o_item;
  logic      o_push;
  logic      o_full;

  // Classify incoming requests
  gebnd_front #(
    .INDEX_BITS(INDEX_BITS)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .row_offset_we    (row_offset_we),
    .row_offset_wdata (row_offset_wdata),
    .entry            (entry),
    .push             (push),
    .full             (full),
    .q_push           (q_push),
    .q_item           (q_in),
    .q_full           (q_full)
  );

  // Decouple front from back
  gebnd_fifo #(
    .WIDTH($bits(cls_item_t)),
    .DEPTH(MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_out),
    .empty (q_empty)
  );

  // Accumulate rows and fold bounds
  gebnd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_item  (q_out),
    .q_pop   (q_pop),
    .o_full  (o_full),
    .o_push  (o_push),
    .o_item  (o_item)
  );

  // Hold results until taken
  gebnd_fifo #(
    .WIDTH($bits(out_item_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (o_push),
    .wdata (o_item),
    .full  (o_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule
